### hdl/isr_pkg.sv
// Shared types and constants for the importance splitting / roulette core.
// Used by every module of the block but the divider; depends on nothing else.
`default_nettype none

package isr_pkg;

  localparam logic [15:0] MAX_SPLIT = 16'd255;

  localparam logic [1:0] STATUS_OK        = 2'd0;
  localparam logic [1:0] STATUS_ZERO_PRE  = 2'd1;
  localparam logic [1:0] STATUS_ZERO_WGT  = 2'd2;
  localparam logic [1:0] STATUS_SATURATED = 2'd3;

  typedef struct packed {
    logic [31:0] importance_before;
    logic [31:0] importance_after;
    logic [31:0] weight_in;
    logic [31:0] random_fraction;
  } req_t;

  typedef struct packed {
    logic [7:0]  split_count;
    logic [31:0] weight_out;
    logic [1:0]  status;
    logic        ratio_warning;
  } res_t;

  typedef enum logic [1:0] {
    KIND_NORMAL,
    KIND_ZERO_POST,
    KIND_ZERO_PRE,
    KIND_ZERO_WEIGHT
  } kind_t;

  typedef enum logic [1:0] {
    REL_LESS,
    REL_EQUAL,
    REL_GREATER
  } rel_t;

  // One classified request as it travels from the front to the back.
  typedef struct packed {
    logic [31:0] pre;
    logic [31:0] post;
    logic [31:0] weight;
    logic [31:0] rnd;
    kind_t       kind;
    rel_t        rel;
    logic        warn;
  } item_t;

endpackage

`default_nettype wire

### hdl/importance_split_roulette_core.sv
// Importance splitting and Russian roulette at a cell boundary.
// A special case (zero importance or weight) skips the multiplier and divider;
// a regular request runs up to two 32-step divisions on the shared radix-2
// divider in the back end, which takes a new request only when idle.
// Reset (synchronous) empties the queue and clears the once-only warning flag.
`default_nettype none

module importance_split_roulette_core (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           req_valid,
  output logic                req_ready,
  input  wire isr_pkg::req_t  req,
  output logic                res_valid,
  input  wire logic           res_ready,
  output isr_pkg::res_t       res
);

  logic            front_valid;
  logic            front_ready;
  isr_pkg::item_t  front_item;
  logic            pop_valid;
  logic            pop_ready;
  isr_pkg::item_t  pop_data;

  isr_front u_front (
    .clk        (clk),
    .rst        (rst),
    .req_valid  (req_valid),
    .req_ready  (req_ready),
    .req        (req),
    .item_valid (front_valid),
    .item_ready (front_ready),
    .item       (front_item)
  );

  isr_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (front_valid),
    .push_ready (front_ready),
    .push_data  (front_item),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  isr_back u_back (
    .clk       (clk),
    .rst       (rst),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_data  (pop_data),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

endmodule

`default_nettype wire

### hdl/isr_front.sv
// Front end: accepts requests, sorts out the special cases, compares the
// importances and raises the once-only ratio warning. Depends on isr_pkg.
`default_nettype none

module isr_front (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           req_valid,
  output logic                req_ready,
  input  wire isr_pkg::req_t  req,
  output logic                item_valid,
  input  wire logic           item_ready,
  output isr_pkg::item_t      item
);

  logic            warned_once;
  isr_pkg::item_t  item_next;
  logic            outside;
  logic            accept;

  assign req_ready = !item_valid || item_ready;
  assign accept    = req_valid && req_ready;

  // The ratio test is exact: both sides are widened by two bits before the shift.
  assign outside =
    ({req.importance_before, 2'b00} < {2'b00, req.importance_after}) ||
    ({2'b00, req.importance_before} > {req.importance_after, 2'b00});

  always_comb begin
    item_next.pre    = req.importance_before;
    item_next.post   = req.importance_after;
    item_next.weight = req.weight_in;
    item_next.rnd    = req.random_fraction;
    item_next.warn   = 1'b0;
    if (req.importance_after == 32'd0) begin
      item_next.kind = isr_pkg::KIND_ZERO_POST;
    end else if (req.importance_before == 32'd0) begin
      item_next.kind = isr_pkg::KIND_ZERO_PRE;
    end else if (req.weight_in == 32'd0) begin
      item_next.kind = isr_pkg::KIND_ZERO_WEIGHT;
    end else begin
      item_next.kind = isr_pkg::KIND_NORMAL;
      item_next.warn = outside && !warned_once;
    end
    if (req.importance_before < req.importance_after) begin
      item_next.rel = isr_pkg::REL_LESS;
    end else if (req.importance_before > req.importance_after) begin
      item_next.rel = isr_pkg::REL_GREATER;
    end else begin
      item_next.rel = isr_pkg::REL_EQUAL;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid  <= 1'b0;
      warned_once <= 1'b0;
    end else begin
      if (accept) begin
        item       <= item_next;
        item_valid <= 1'b1;
        if (item_next.warn) begin
          warned_once <= 1'b1;
        end
      end else if (item_valid && item_ready) begin
        item_valid <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

### hdl/isr_queue.sv
// Two-entry queue of classified requests between the front and the back.
// Depends on isr_pkg for the entry type.
`default_nettype none

module isr_queue (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            push_valid,
  output logic                 push_ready,
  input  wire isr_pkg::item_t  push_data,
  output logic                 pop_valid,
  input  wire logic            pop_ready,
  output isr_pkg::item_t       pop_data
);

  isr_pkg::item_t  entries [2];
  logic            wr_ptr;
  logic            rd_ptr;
  logic [1:0]      fill;
  logic            push;
  logic            pop;

  assign push_ready = (fill != 2'd2);
  assign pop_valid  = (fill != 2'd0);
  assign pop_data   = entries[rd_ptr];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      if (push && !pop) begin
        fill <= fill + 2'd1;
      end else if (pop && !push) begin
        fill <= fill - 2'd1;
      end
    end
  end

endmodule

`default_nettype wire

### hdl/isr_divider.sv
// Radix-2 restoring divider, one quotient bit per cycle.
// Divides a 64-bit dividend whose high word is below the divisor. No dependencies.
`default_nettype none

module isr_divider (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic [31:0] dividend_hi,
  input  wire logic [31:0] dividend_lo,
  input  wire logic [31:0] divisor,
  output logic             done,
  output logic [31:0]      quotient,
  output logic [31:0]      remainder
);

  logic        busy;
  logic [4:0]  step;
  logic [31:0] div_reg;
  logic [32:0] shifted;
  logic [32:0] diff;

  // The low word shifts out at the top while quotient bits enter at the bottom.
  assign shifted = {remainder, quotient[31]};
  assign diff    = shifted - {1'b0, div_reg};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= 5'd0;
    end else begin
      done <= !start && busy && (step == 5'd31);
      if (start) begin
        busy      <= 1'b1;
        step      <= 5'd0;
        remainder <= dividend_hi;
        quotient  <= dividend_lo;
        div_reg   <= divisor;
      end else if (busy) begin
        if (!diff[32]) begin
          remainder <= diff[31:0];
          quotient  <= {quotient[30:0], 1'b1};
        end else begin
          remainder <= shifted[31:0];
          quotient  <= {quotient[30:0], 1'b0};
        end
        step <= step + 5'd1;
        if (step == 5'd31) begin
          busy <= 1'b0;
        end
      end
    end
  end

endmodule

`default_nettype wire

### hdl/isr_back.sv
// Back end: carries out one classified request with a shared multiplier and
// the shared divider, then saturates and registers the result. Depends on isr_pkg.
`default_nettype none

module isr_back (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            pop_valid,
  output logic                 pop_ready,
  input  wire isr_pkg::item_t  pop_data,
  output logic                 res_valid,
  input  wire logic            res_ready,
  output isr_pkg::res_t        res
);

  typedef enum logic [2:0] {
    IDLE,
    MUL_R,
    MUL_W,
    DIV_CNT,
    ADJUST,
    DIV_WT,
    FINISH
  } state_t;

  state_t          state;
  isr_pkg::item_t  cur;
  logic [63:0]     prod;
  logic [63:0]     prod_next;
  logic [31:0]     rnd_hi;
  logic [31:0]     quotient;
  logic [31:0]     remainder;
  logic [32:0]     count;
  logic [32:0]     count_next;
  logic            killed;
  logic            kill_next;
  logic            wsat;
  logic            wt_over;
  isr_pkg::res_t   res_next;
  logic            count_sat;
  logic [15:0]     count_clip;

  logic            div_start;
  logic [31:0]     div_hi;
  logic [31:0]     div_lo;
  logic [31:0]     div_divisor;
  logic            div_done;
  logic [31:0]     div_quo;
  logic [31:0]     div_rem;

  assign pop_ready = (state == IDLE);

  // One multiplier serves both products; both share the pre importance.
  assign prod_next = ((state == MUL_R) ? cur.rnd : cur.weight) * cur.pre;

  // r < x/pre is tested as r*pre < x*2^32, i.e. the product's high word below x.
  assign kill_next = (cur.rel == isr_pkg::REL_GREATER) && (rnd_hi < (cur.pre - cur.post));
  assign wt_over   = (prod[63:32] >= cur.post);

  always_comb begin
    case (cur.rel)
      isr_pkg::REL_LESS: begin
        count_next = {1'b0, quotient} +
                     {32'd0, (remainder != 32'd0) && (rnd_hi < remainder)};
      end
      default: begin
        count_next = 33'd1;
      end
    endcase
  end

  always_comb begin
    div_start = (state == MUL_W) || ((state == ADJUST) && !kill_next && !wt_over);
    if (state == MUL_W) begin
      div_hi      = 32'd0;
      div_lo      = cur.post;
      div_divisor = cur.pre;
    end else begin
      div_hi      = prod[63:32];
      div_lo      = prod[31:0];
      div_divisor = cur.post;
    end
  end

  isr_divider u_divider (
    .clk         (clk),
    .rst         (rst),
    .start       (div_start),
    .dividend_hi (div_hi),
    .dividend_lo (div_lo),
    .divisor     (div_divisor),
    .done        (div_done),
    .quotient    (div_quo),
    .remainder   (div_rem)
  );

  assign count_sat  = (count > {17'd0, isr_pkg::MAX_SPLIT});
  assign count_clip = count_sat ? isr_pkg::MAX_SPLIT : count[15:0];

  always_comb begin
    res_next.split_count   = 8'd0;
    res_next.weight_out    = 32'd0;
    res_next.status        = isr_pkg::STATUS_OK;
    res_next.ratio_warning = 1'b0;
    case (cur.kind)
      isr_pkg::KIND_ZERO_PRE: begin
        res_next.status = isr_pkg::STATUS_ZERO_PRE;
      end
      isr_pkg::KIND_ZERO_WEIGHT: begin
        res_next.status = isr_pkg::STATUS_ZERO_WGT;
      end
      isr_pkg::KIND_NORMAL: begin
        res_next.ratio_warning = cur.warn;
        if (!killed) begin
          res_next.split_count = count_clip[7:0];
          res_next.weight_out  = wsat ? 32'hFFFF_FFFF : quotient;
          if (count_sat || wsat) begin
            res_next.status = isr_pkg::STATUS_SATURATED;
          end
        end
      end
      default: begin
        res_next.status = isr_pkg::STATUS_OK;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= IDLE;
      res_valid <= 1'b0;
    end else begin
      // In FINISH the output register is either reloaded or still waiting.
      if (res_valid && res_ready && (state != FINISH)) begin
        res_valid <= 1'b0;
      end
      case (state)
        IDLE: begin
          if (pop_valid) begin
            cur    <= pop_data;
            killed <= 1'b0;
            wsat   <= 1'b0;
            state  <= (pop_data.kind == isr_pkg::KIND_NORMAL) ? MUL_R : FINISH;
          end
        end
        MUL_R: begin
          prod  <= prod_next;
          state <= MUL_W;
        end
        MUL_W: begin
          rnd_hi <= prod[63:32];
          prod   <= prod_next;
          state  <= DIV_CNT;
        end
        DIV_CNT: begin
          if (div_done) begin
            quotient  <= div_quo;
            remainder <= div_rem;
            state     <= ADJUST;
          end
        end
        ADJUST: begin
          count  <= count_next;
          killed <= kill_next;
          if (kill_next) begin
            state <= FINISH;
          end else if (wt_over) begin
            wsat  <= 1'b1;
            state <= FINISH;
          end else begin
            state <= DIV_WT;
          end
        end
        DIV_WT: begin
          if (div_done) begin
            quotient <= div_quo;
            state    <= FINISH;
          end
        end
        FINISH: begin
          if (!res_valid || res_ready) begin
            res       <= res_next;
            res_valid <= 1'b1;
            state     <= IDLE;
          end
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire
